/* sv/tld_pkg.sv */
// ----------------------------------------------------------------------------
// tld_pkg
// Shared codes, characters and the ring command type of the line discipline.
// ----------------------------------------------------------------------------
package tld_pkg;

  localparam logic [2:0] OP_RECV  = 3'd0;
  localparam logic [2:0] OP_PUT   = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_DRAIN = 3'd3;
  localparam logic [2:0] OP_FLUSH = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_OVF   = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_INTR  = 3'd3;
  localparam logic [2:0] ST_QUIT  = 3'd4;
  localparam logic [2:0] ST_SUSP  = 3'd5;
  localparam logic [2:0] ST_EOF   = 3'd6;

  localparam logic [1:0] FL_INPUT  = 2'd0;
  localparam logic [1:0] FL_OUTPUT = 2'd1;

  localparam logic [2:0] REG_RAW     = 3'd0;
  localparam logic [2:0] REG_LFLAGS  = 3'd1;
  localparam logic [2:0] REG_IFLAGS  = 3'd2;
  localparam logic [2:0] REG_OFLAGS  = 3'd3;
  localparam logic [2:0] REG_SPECIAL = 3'd4;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_SP = 8'h20;

  localparam logic [4:0]  LFLAGS_RESET  = 5'd31;
  localparam logic [1:0]  IFLAGS_RESET  = 2'd1;
  localparam logic [1:0]  OFLAGS_RESET  = 2'd3;
  localparam logic [47:0] SPECIAL_RESET = 48'h0415_081A_1C03;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       back;
    logic       clear;
    logic [7:0] data;
  } ring_cmd_t;

endpackage

/* sv/tld_ring.sv */
// ----------------------------------------------------------------------------
// tld_ring
// Byte ring buffer on a synchronous memory: push, pop, step back and clear.
// ----------------------------------------------------------------------------
module tld_ring #(
  parameter int DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tld_pkg::ring_cmd_t           cmd,
  output logic [$clog2(DEPTH+1)-1:0]   fill,
  output logic                         full,
  output logic                         empty,
  output logic [7:0]                   rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] rd_r, rd_nxt;
  logic [AW-1:0] wr_r, wr_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]    rd_data_r;

  assign fill    = fill_r;
  assign full    = (fill_r == FW'(DEPTH));
  assign empty   = (fill_r == '0);
  assign rd_data = rd_data_r;

  always_comb begin
    rd_nxt   = rd_r;
    wr_nxt   = wr_r;
    fill_nxt = fill_r;
    if (cmd.clear) begin
      rd_nxt   = '0;
      wr_nxt   = '0;
      fill_nxt = '0;
    end else if (cmd.push && !full) begin
      wr_nxt   = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
      fill_nxt = fill_r + FW'(1);
    end else if (cmd.pop && !empty) begin
      rd_nxt   = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
      fill_nxt = fill_r - FW'(1);
    end else if (cmd.back && !empty) begin
      wr_nxt   = (wr_r == '0) ? AW'(DEPTH - 1) : wr_r - AW'(1);
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r   <= '0;
      wr_r   <= '0;
      fill_r <= '0;
    end else begin
      rd_r   <= rd_nxt;
      wr_r   <= wr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !full && !cmd.clear) begin
      mem[wr_r] <= cmd.data;
    end
    if (cmd.pop) begin
      rd_data_r <= mem[rd_r];
    end
  end

endmodule

/* sv/tty_line_discipline_unit.sv */
// ----------------------------------------------------------------------------
// tty_line_discipline_unit
// Terminal line discipline with input and output byte ring buffers.
// ----------------------------------------------------------------------------
// Takes one operation item at a time and returns one result item for it. An
// item passes through accept, execute and result; each extra byte written to
// the output buffer adds a push state, as the output memory takes one write
// a cycle: a put expanding NL to CR NL passes through S_PUSH2 and an erase
// with echo through S_PUSH2 and S_PUSH3. A result not taken stalls the next
// item in S_DONE until out_tready. Both buffers start empty after reset with
// no clearing pass. Configuration writes are taken at any time (cfg_ready is
// always high) and must only be issued while the block is idle.
module tty_line_discipline_unit #(
  parameter int INPUT_DEPTH  = 256,
  parameter int OUTPUT_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // operation[2:0], char_in[10:3], flush_select[12:11]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // status[2:0], data_out[10:3], input_level[19:11],
                                  // output_level[28:20]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int IFW = $clog2(INPUT_DEPTH + 1);
  localparam int OFW = $clog2(OUTPUT_DEPTH + 1);
  localparam int ILW = (IFW > 9) ? IFW : 9;
  localparam int OLW = (OFW > 9) ? OFW : 9;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_PUSH2 = 3'd2;
  localparam logic [2:0] S_PUSH3 = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_IN   = 2'd1;
  localparam logic [1:0] SRC_OUT  = 2'd2;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  op_r;
  logic [7:0]  ch_r;
  logic [1:0]  sel_r;
  logic [2:0]  status_r, status_nxt;
  logic        drop_r, drop_nxt;
  logic [1:0]  src_r, src_nxt;
  logic [7:0]  ob1_r, ob1_nxt;
  logic [1:0]  ocnt_r, ocnt_nxt;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  logic        raw_r;
  logic [4:0]  lflags_r;
  logic [1:0]  iflags_r;
  logic [1:0]  oflags_r;
  logic [47:0] special_r;

  tld_pkg::ring_cmd_t in_cmd, out_cmd;
  logic [IFW-1:0] in_fill;
  logic [OFW-1:0] out_fill;
  logic           in_full, in_empty, out_full, out_empty;
  logic [7:0]     in_rd_data, out_rd_data;

  logic [7:0]     ch_xl;
  logic [7:0]     data_sel;
  logic [ILW-1:0] in_lvl;
  logic [OLW-1:0] out_lvl;
  logic           slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign slot_free  = !out_valid_r || out_tready;

  tld_ring #(.DEPTH(INPUT_DEPTH)) u_in_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (in_cmd),
    .fill    (in_fill),
    .full    (in_full),
    .empty   (in_empty),
    .rd_data (in_rd_data)
  );

  tld_ring #(.DEPTH(OUTPUT_DEPTH)) u_out_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (out_cmd),
    .fill    (out_fill),
    .full    (out_full),
    .empty   (out_empty),
    .rd_data (out_rd_data)
  );

  always_comb begin
    ch_xl = ch_r;
    if (iflags_r[0] && ch_xl == tld_pkg::CH_CR) ch_xl = tld_pkg::CH_NL;
    if (iflags_r[1] && ch_xl == tld_pkg::CH_NL) ch_xl = tld_pkg::CH_CR;
  end

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    drop_nxt   = drop_r;
    src_nxt    = src_r;
    ob1_nxt    = ob1_r;
    ocnt_nxt   = ocnt_r;
    in_cmd     = '0;
    out_cmd    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = tld_pkg::ST_OK;
        drop_nxt   = 1'b0;
        src_nxt    = SRC_NONE;
        ocnt_nxt   = 2'd0;
        unique case (op_r)
          tld_pkg::OP_RECV: begin
            priority if (raw_r) begin
              in_cmd.push = 1'b1;
              in_cmd.data = ch_r;
            end else if (lflags_r[0] && ch_r == special_r[7:0]) begin
              status_nxt = tld_pkg::ST_INTR;
            end else if (lflags_r[0] && ch_r == special_r[15:8]) begin
              status_nxt = tld_pkg::ST_QUIT;
            end else if (lflags_r[0] && ch_r == special_r[23:16]) begin
              status_nxt = tld_pkg::ST_SUSP;
            end else if (lflags_r[1] && ch_r == special_r[31:24]) begin
              if (!in_empty) begin
                in_cmd.back = 1'b1;
                if (lflags_r[3]) begin
                  out_cmd.push = 1'b1;
                  out_cmd.data = tld_pkg::CH_BS;
                  ob1_nxt      = tld_pkg::CH_SP;
                  ocnt_nxt     = 2'd3;
                end
              end
            end else if (lflags_r[1] && ch_r == special_r[39:32]) begin
              in_cmd.clear = 1'b1;
              if (lflags_r[4]) begin
                out_cmd.push = 1'b1;
                out_cmd.data = tld_pkg::CH_NL;
              end
            end else if (lflags_r[1] && ch_r == special_r[47:40]) begin
              status_nxt = tld_pkg::ST_EOF;
            end else begin
              in_cmd.push = 1'b1;
              in_cmd.data = ch_xl;
              if (lflags_r[2]) begin
                out_cmd.push = 1'b1;
                out_cmd.data = ch_xl;
              end
            end
          end
          tld_pkg::OP_PUT: begin
            out_cmd.push = 1'b1;
            if (!raw_r && oflags_r[0] && oflags_r[1] && ch_r == tld_pkg::CH_NL) begin
              out_cmd.data = tld_pkg::CH_CR;
              ob1_nxt      = tld_pkg::CH_NL;
              ocnt_nxt     = 2'd2;
            end else begin
              out_cmd.data = ch_r;
            end
          end
          tld_pkg::OP_READ: begin
            if (in_empty) begin
              status_nxt = tld_pkg::ST_EMPTY;
            end else begin
              in_cmd.pop = 1'b1;
              src_nxt    = SRC_IN;
            end
          end
          tld_pkg::OP_DRAIN: begin
            if (out_empty) begin
              status_nxt = tld_pkg::ST_EMPTY;
            end else begin
              out_cmd.pop = 1'b1;
              src_nxt     = SRC_OUT;
            end
          end
          tld_pkg::OP_FLUSH: begin
            in_cmd.clear  = (sel_r != tld_pkg::FL_OUTPUT);
            out_cmd.clear = (sel_r != tld_pkg::FL_INPUT);
          end
          default: begin
          end
        endcase
        drop_nxt  = (in_cmd.push && in_full) || (out_cmd.push && out_full);
        state_nxt = (ocnt_nxt != 2'd0) ? S_PUSH2 : S_DONE;
      end
      S_PUSH2: begin
        out_cmd.push = 1'b1;
        out_cmd.data = ob1_r;
        drop_nxt     = drop_r | out_full;
        state_nxt    = (ocnt_r == 2'd3) ? S_PUSH3 : S_DONE;
      end
      S_PUSH3: begin
        out_cmd.push = 1'b1;
        out_cmd.data = tld_pkg::CH_BS;
        drop_nxt     = drop_r | out_full;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    unique case (src_r)
      SRC_IN:  data_sel = in_rd_data;
      SRC_OUT: data_sel = out_rd_data;
      default: data_sel = 8'd0;
    endcase
    in_lvl  = ILW'(in_fill);
    out_lvl = OLW'(out_fill);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      raw_r       <= 1'b0;
      lflags_r    <= tld_pkg::LFLAGS_RESET;
      iflags_r    <= tld_pkg::IFLAGS_RESET;
      oflags_r    <= tld_pkg::OFLAGS_RESET;
      special_r   <= tld_pkg::SPECIAL_RESET;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          tld_pkg::REG_RAW:     raw_r     <= cfg_data[0];
          tld_pkg::REG_LFLAGS:  lflags_r  <= cfg_data[4:0];
          tld_pkg::REG_IFLAGS:  iflags_r  <= cfg_data[1:0];
          tld_pkg::REG_OFLAGS:  oflags_r  <= cfg_data[1:0];
          tld_pkg::REG_SPECIAL: special_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    drop_r   <= drop_nxt;
    src_r    <= src_nxt;
    ob1_r    <= ob1_nxt;
    ocnt_r   <= ocnt_nxt;
    if (in_tvalid && in_tready) begin
      op_r  <= in_tdata[2:0];
      ch_r  <= in_tdata[10:3];
      sel_r <= in_tdata[12:11];
    end
    if (state_r == S_DONE && slot_free) begin
      out_data_r[2:0]   <= drop_r ? tld_pkg::ST_OVF : status_r;
      out_data_r[10:3]  <= data_sel;
      out_data_r[19:11] <= in_lvl[8:0];
      out_data_r[28:20] <= out_lvl[8:0];
      out_data_r[31:29] <= 3'd0;
    end
  end

endmodule

/* tb/sv/tty_line_discipline_unit_tb.sv */
// ----------------------------------------------------------------------------
// tty_line_discipline_unit_tb
// Self-checking testbench for the terminal line discipline unit.
// ----------------------------------------------------------------------------
// Every accepted operation item is run through a local model of both ring
// buffers, the cooked-mode character handling and the output expansion. The
// predicted status, data and fill levels are queued, and each result item
// leaving the block is checked against the oldest one. Directed items cover
// every operation and the special characters. Then come overflow of both
// rings, typed lines with editing, and random traffic under a sweep of
// register settings. Sender gaps and receiver stalls are drawn per item.
// ----------------------------------------------------------------------------
module tty_line_discipline_unit_tb;

  localparam int RING_DEPTH     = 256;
  localparam int STALL_MAX      = 18;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  localparam int SP_INTR  = 0;
  localparam int SP_QUIT  = 1;
  localparam int SP_SUSP  = 2;
  localparam int SP_ERASE = 3;
  localparam int SP_KILL  = 4;
  localparam int SP_EOF   = 5;

  localparam int LF_SIG   = 0;
  localparam int LF_CANON = 1;
  localparam int LF_ECHO  = 2;
  localparam int LF_ECHOE = 3;
  localparam int LF_ECHOK = 4;
  localparam int IF_ICRNL = 0;
  localparam int IF_INLCR = 1;
  localparam int OF_OPOST = 0;
  localparam int OF_ONLCR = 1;

  localparam logic [1:0] FL_BOTH     = 2'd2;
  localparam logic [1:0] FL_BOTH_ALT = 2'd3;
  localparam logic [2:0] OP_SPARE5   = 3'd5;
  localparam logic [2:0] OP_SPARE6   = 3'd6;
  localparam logic [2:0] OP_SPARE7   = 3'd7;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data;
    logic [8:0] in_level;
    logic [8:0] out_level;
  } tty_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // operation[2:0], char_in[10:3], flush_select[12:11]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // status[2:0], data_out[10:3], input_level[19:11],
                                  // output_level[28:20]
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [47:0] cfg_data   = '0;

  tty_line_discipline_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  logic [7:0]  rx_mem [RING_DEPTH];
  logic [7:0]  tx_mem [RING_DEPTH];
  logic [7:0]  rx_rd = '0, rx_wr = '0, tx_rd = '0, tx_wr = '0;
  logic [8:0]  rx_fill = '0, tx_fill = '0;

  logic        cur_raw     = 1'b0;
  logic [4:0]  cur_lflags  = tld_pkg::LFLAGS_RESET;
  logic [1:0]  cur_iflags  = tld_pkg::IFLAGS_RESET;
  logic [1:0]  cur_oflags  = tld_pkg::OFLAGS_RESET;
  logic [47:0] cur_special = tld_pkg::SPECIAL_RESET;

  tty_result_t expected_results[$];
  int fail_count     = 0;
  int items_sent     = 0;
  int settings_used  = 1;
  int idle_cycles    = 0;
  bit in_gaps        = 1'b1;
  bit out_stalls     = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] special_byte(int k);
    return cur_special[8*k +: 8];
  endfunction

  function automatic logic rx_push(logic [7:0] c);
    if (rx_fill >= RING_DEPTH) return 1'b1;
    rx_mem[rx_wr] = c;
    rx_wr = rx_wr + 8'd1;
    rx_fill = rx_fill + 9'd1;
    return 1'b0;
  endfunction

  function automatic logic tx_push(logic [7:0] c);
    if (tx_fill >= RING_DEPTH) return 1'b1;
    tx_mem[tx_wr] = c;
    tx_wr = tx_wr + 8'd1;
    tx_fill = tx_fill + 9'd1;
    return 1'b0;
  endfunction

  function automatic logic [2:0] cook_receive(logic [7:0] c_in);
    logic [7:0] c;
    logic drop;
    c = c_in;
    drop = 1'b0;
    if (cur_raw) return rx_push(c) ? tld_pkg::ST_OVF : tld_pkg::ST_OK;
    if (cur_lflags[LF_SIG]) begin
      if (c == special_byte(SP_INTR)) return tld_pkg::ST_INTR;
      if (c == special_byte(SP_QUIT)) return tld_pkg::ST_QUIT;
      if (c == special_byte(SP_SUSP)) return tld_pkg::ST_SUSP;
    end
    if (cur_lflags[LF_CANON]) begin
      if (c == special_byte(SP_ERASE)) begin
        if (rx_fill != 0) begin
          rx_wr = rx_wr - 8'd1;
          rx_fill = rx_fill - 9'd1;
          if (cur_lflags[LF_ECHOE]) begin
            drop = drop | tx_push(tld_pkg::CH_BS);
            drop = drop | tx_push(tld_pkg::CH_SP);
            drop = drop | tx_push(tld_pkg::CH_BS);
          end
        end
        return drop ? tld_pkg::ST_OVF : tld_pkg::ST_OK;
      end
      if (c == special_byte(SP_KILL)) begin
        rx_rd = '0;
        rx_wr = '0;
        rx_fill = '0;
        if (cur_lflags[LF_ECHOK]) drop = tx_push(tld_pkg::CH_NL);
        return drop ? tld_pkg::ST_OVF : tld_pkg::ST_OK;
      end
      if (c == special_byte(SP_EOF)) return tld_pkg::ST_EOF;
    end
    if (cur_iflags[IF_ICRNL] && c == tld_pkg::CH_CR) c = tld_pkg::CH_NL;
    if (cur_iflags[IF_INLCR] && c == tld_pkg::CH_NL) c = tld_pkg::CH_CR;
    drop = rx_push(c);
    if (cur_lflags[LF_ECHO]) drop = drop | tx_push(c);
    return drop ? tld_pkg::ST_OVF : tld_pkg::ST_OK;
  endfunction

  function automatic logic [2:0] expand_put(logic [7:0] c);
    logic drop;
    if (!cur_raw && cur_oflags[OF_OPOST] && cur_oflags[OF_ONLCR] &&
        c == tld_pkg::CH_NL) begin
      drop = tx_push(tld_pkg::CH_CR);
      drop = drop | tx_push(tld_pkg::CH_NL);
      return drop ? tld_pkg::ST_OVF : tld_pkg::ST_OK;
    end
    return tx_push(c) ? tld_pkg::ST_OVF : tld_pkg::ST_OK;
  endfunction

  function automatic tty_result_t predict_step(logic [2:0] op, logic [7:0] ch, logic [1:0] sel);
    tty_result_t r;
    logic [2:0] st;
    logic [7:0] d;
    st = tld_pkg::ST_OK;
    d = '0;
    case (op)
      tld_pkg::OP_RECV: st = cook_receive(ch);
      tld_pkg::OP_PUT:  st = expand_put(ch);
      tld_pkg::OP_READ: begin
        if (rx_fill == 0) st = tld_pkg::ST_EMPTY;
        else begin
          d = rx_mem[rx_rd];
          rx_rd = rx_rd + 8'd1;
          rx_fill = rx_fill - 9'd1;
        end
      end
      tld_pkg::OP_DRAIN: begin
        if (tx_fill == 0) st = tld_pkg::ST_EMPTY;
        else begin
          d = tx_mem[tx_rd];
          tx_rd = tx_rd + 8'd1;
          tx_fill = tx_fill - 9'd1;
        end
      end
      tld_pkg::OP_FLUSH: begin
        if (sel != tld_pkg::FL_OUTPUT) begin
          rx_rd = '0;
          rx_wr = '0;
          rx_fill = '0;
        end
        if (sel != tld_pkg::FL_INPUT) begin
          tx_rd = '0;
          tx_wr = '0;
          tx_fill = '0;
        end
      end
      default: ;
    endcase
    r.status = st;
    r.data = d;
    r.in_level = rx_fill;
    r.out_level = tx_fill;
    return r;
  endfunction

  function automatic logic [7:0] random_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return special_byte($urandom_range(0, 5));
      4:          return tld_pkg::CH_CR;
      5:          return tld_pkg::CH_NL;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [47:0] random_special();
    logic [47:0] sp;
    logic [7:0] b, prev;
    int k;
    sp = '0;
    prev = 8'h00;
    for (k = 0; k < 6; k++) begin
      case ($urandom_range(0, 7))
        0:       b = tld_pkg::CH_CR;
        1:       b = tld_pkg::CH_NL;
        2:       b = prev;
        default: b = 8'($urandom_range(0, 255));
      endcase
      sp[8*k +: 8] = b;
      prev = b;
    end
    return sp;
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [7:0] ch, input logic [1:0] sel);
    int gap;
    gap = in_gaps ? $urandom_range(0, STALL_MAX) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, sel, ch, op};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_step(op, ch, sel));
    items_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tld_pkg::REG_RAW:     cur_raw = val[0];
      tld_pkg::REG_LFLAGS:  cur_lflags = val[4:0];
      tld_pkg::REG_IFLAGS:  cur_iflags = val[1:0];
      tld_pkg::REG_OFLAGS:  cur_oflags = val[1:0];
      tld_pkg::REG_SPECIAL: cur_special = val;
      default: ;
    endcase
  endtask

  task automatic write_config(input logic raw, input logic [4:0] lf, input logic [1:0] ifl,
                              input logic [1:0] ofl, input logic [47:0] sp);
    wait_idle();
    put_reg(tld_pkg::REG_RAW, {47'd0, raw});
    put_reg(tld_pkg::REG_LFLAGS, {43'd0, lf});
    put_reg(tld_pkg::REG_IFLAGS, {46'd0, ifl});
    put_reg(tld_pkg::REG_OFLAGS, {46'd0, ofl});
    put_reg(tld_pkg::REG_SPECIAL, sp);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_traffic(input int count);
    int i, r;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        send_item(tld_pkg::OP_RECV, random_char(), 2'($urandom_range(0, 3)));
      else if (r < 58)
        send_item(tld_pkg::OP_PUT, random_char(), 2'($urandom_range(0, 3)));
      else if (r < 72)
        send_item(tld_pkg::OP_READ, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
      else if (r < 88)
        send_item(tld_pkg::OP_DRAIN, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
      else if (r < 94)
        send_item(tld_pkg::OP_FLUSH, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
      else
        send_item(3'($urandom_range(OP_SPARE5, OP_SPARE7)), 8'($urandom_range(0, 255)),
                  2'($urandom_range(0, 3)));
    end
  endtask

  task automatic test_directed();
    send_item(tld_pkg::OP_RECV, 8'h61, tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_RECV, tld_pkg::CH_CR, tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_RECV, 8'hFF, FL_BOTH_ALT);
    send_item(tld_pkg::OP_RECV, special_byte(SP_ERASE), tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_RECV, special_byte(SP_KILL), tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_RECV, special_byte(SP_ERASE), tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_RECV, special_byte(SP_INTR), tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_RECV, special_byte(SP_QUIT), tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_RECV, special_byte(SP_SUSP), tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_RECV, special_byte(SP_EOF), tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_RECV, 8'h00, tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_PUT, tld_pkg::CH_NL, tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_PUT, 8'hFF, tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_READ, 8'h00, tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_READ, 8'hFF, FL_BOTH_ALT);
    send_item(tld_pkg::OP_DRAIN, 8'h00, tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_FLUSH, 8'h00, tld_pkg::FL_OUTPUT);
    send_item(tld_pkg::OP_DRAIN, 8'h00, tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_RECV, 8'h62, tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_PUT, 8'h63, tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_FLUSH, 8'h00, tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_FLUSH, 8'hFF, FL_BOTH);
    send_item(tld_pkg::OP_FLUSH, 8'h00, FL_BOTH_ALT);
    send_item(OP_SPARE5, 8'hFF, FL_BOTH_ALT);
    send_item(OP_SPARE6, 8'h00, tld_pkg::FL_INPUT);
    send_item(OP_SPARE7, 8'h5A, tld_pkg::FL_OUTPUT);
  endtask

  task automatic test_ring_overflow();
    int i;
    write_config(1'b1, tld_pkg::LFLAGS_RESET, tld_pkg::IFLAGS_RESET, tld_pkg::OFLAGS_RESET,
                 tld_pkg::SPECIAL_RESET);
    for (i = 0; i <= RING_DEPTH; i++)
      send_item(tld_pkg::OP_RECV, 8'($urandom_range(0, 255)), tld_pkg::FL_INPUT);
    for (i = 0; i <= RING_DEPTH; i++)
      send_item(tld_pkg::OP_PUT, 8'($urandom_range(0, 255)), tld_pkg::FL_INPUT);
    write_config(1'b0, tld_pkg::LFLAGS_RESET, tld_pkg::IFLAGS_RESET, tld_pkg::OFLAGS_RESET,
                 tld_pkg::SPECIAL_RESET);
    send_item(tld_pkg::OP_RECV, 8'($urandom_range(8'h30, 8'h39)), tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_DRAIN, 8'h00, tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_RECV, 8'($urandom_range(8'h30, 8'h39)), tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_DRAIN, 8'h00, tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_DRAIN, 8'h00, tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_RECV, special_byte(SP_ERASE), tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_DRAIN, 8'h00, tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_PUT, tld_pkg::CH_NL, tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_READ, 8'h00, tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_RECV, 8'($urandom_range(8'h30, 8'h39)), tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_RECV, special_byte(SP_KILL), tld_pkg::FL_INPUT);
    send_item(tld_pkg::OP_FLUSH, 8'h00, FL_BOTH);
  endtask

  task automatic test_line_editing();
    int ln, k, len, r, n;
    write_config(1'b0, tld_pkg::LFLAGS_RESET, tld_pkg::IFLAGS_RESET, tld_pkg::OFLAGS_RESET,
                 tld_pkg::SPECIAL_RESET);
    for (ln = 0; ln < 12; ln++) begin
      len = $urandom_range(1, 12);
      for (k = 0; k < len; k++) begin
        r = $urandom_range(0, 39);
        if (r < 5)
          send_item(tld_pkg::OP_RECV, special_byte(SP_ERASE), 2'($urandom_range(0, 3)));
        else if (r == 5)
          send_item(tld_pkg::OP_RECV, special_byte(SP_KILL), 2'($urandom_range(0, 3)));
        else if (r == 6)
          send_item(tld_pkg::OP_RECV, special_byte(SP_INTR), 2'($urandom_range(0, 3)));
        else if (r == 7)
          send_item(tld_pkg::OP_PUT, random_char(), 2'($urandom_range(0, 3)));
        else
          send_item(tld_pkg::OP_RECV, 8'($urandom_range(8'h20, 8'h7E)),
                    2'($urandom_range(0, 3)));
      end
      send_item(tld_pkg::OP_RECV, ($urandom_range(0, 1) != 0) ? tld_pkg::CH_CR : tld_pkg::CH_NL,
                tld_pkg::FL_INPUT);
      n = int'(rx_fill);
      for (k = 0; k <= n; k++)
        send_item(tld_pkg::OP_READ, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
      n = int'(tx_fill);
      for (k = 0; k <= n; k++)
        send_item(tld_pkg::OP_DRAIN, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
    end
  endtask

  task automatic test_config_sweep();
    int s;
    for (s = 0; s < 7; s++) begin
      case (s)
        0: write_config(1'b0, 5'd0, 2'd0, 2'd0, 48'd0);
        1: write_config(1'b1, 5'd31, 2'd3, 2'd3, '1);
        2: write_config(1'b0, 5'd31, 2'd3, 2'd3, '1);
        3: write_config(1'b0, 5'd31, 2'd2, 2'd1, tld_pkg::SPECIAL_RESET);
        default: write_config($urandom_range(0, 3) == 0, 5'($urandom_range(0, 31)),
                              2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                              random_special());
      endcase
      in_gaps = (s != 2) && ($urandom_range(0, 3) != 0);
      out_stalls = (s != 2) && ($urandom_range(0, 3) != 0);
      random_traffic(90);
    end
    in_gaps = 1'b1;
    out_stalls = 1'b1;
  endtask

  initial begin : result_sink
    int stall;
    forever begin
      stall = out_stalls ? $urandom_range(0, STALL_MAX) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_tvalid));
    end
  end

  always @(posedge clk) begin : result_check
    tty_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result item with no expectation pending: tdata %h", out_tdata);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[2:0] !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_tdata[2:0]);
          fail_count++;
        end
        if (out_tdata[10:3] !== want.data) begin
          $error("data_out mismatch: expected %h, got %h", want.data, out_tdata[10:3]);
          fail_count++;
        end
        if (out_tdata[19:11] !== want.in_level) begin
          $error("input_level mismatch: expected %0d, got %0d", want.in_level,
                 out_tdata[19:11]);
          fail_count++;
        end
        if (out_tdata[28:20] !== want.out_level) begin
          $error("output_level mismatch: expected %0d, got %0d", want.out_level,
                 out_tdata[28:20]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("** tty_line_discipline_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_ring_overflow();
    test_line_editing();
    test_config_sweep();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d items over %0d register settings, with both rings overflowed",
             items_sent, settings_used);
    $display("and line editing, signals and flushes under random gaps and stalls.");
    if (fail_count == 0 && expected_results.size() == 0)
      $display("** tty_line_discipline_unit: PASSED **");
    else
      $display("** tty_line_discipline_unit: FAILED **");
    $finish;
  end

endmodule
